### design/ordered_list_insert_store_core_defines.svh
// Assertion macros shared by the ordered list store RTL.
// Needs signal clk in the scope of each use, and rst for OLIS_ASSERT.
`ifndef ORDERED_LIST_INSERT_STORE_CORE_DEFINES_SVH
`define ORDERED_LIST_INSERT_STORE_CORE_DEFINES_SVH

// Checked only outside reset.
`define OLIS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked in every cycle, reset included.
`define OLIS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/olis_pkg.sv
// Package for the ordered list store: sizes, mode codes and status codes.
// No dependencies.
`default_nettype none
package olis_pkg;

  localparam int DEPTH  = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int VAL_W  = 32;
  localparam int POS_W  = 6;
  localparam int OIDX_W = 5;
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_POS   = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

endpackage
`default_nettype wire

### design/ordered_list_insert_store_core.sv
// Ordered list store: element memory, insert shifter and read-out sequencer.
// Depends on olis_pkg and ordered_list_insert_store_core_defines.svh.
//
// Usage: drive mode, position and value and raise start; the word is taken
// at a clock edge where start is high and busy is low. Each result word is
// shown on out_value, out_index, status and last for exactly one cycle with
// strobe high; the receiver cannot hold results off, so it must take them.
// Append and insert give one status word. An insert at position p with
// count n elements moves n-p elements, each through the registered read
// of the element memory: a read state and a write state per element
// (S_SH_RD, S_SH_WR), then one write of the new value (S_INS); busy stays
// high meanwhile and the status word is shown in the cycle where busy
// drops. An append goes straight to the write of the new value.
// A rejected insert or append (bad position, full list) shows its status
// word in the cycle right after acceptance and busy stays low. Read-out
// issues one memory read per cycle and emits one element word per cycle;
// each word passes the memory read register and the output register, and
// busy stays high until the last element word is shown.
// An empty list gives a single empty-status word. Mode 3 is dropped.
// Reset clears the element count and the sequencer; memory contents are
// not cleared and need not be, since only entries below the count are read.
`default_nettype none
`include "ordered_list_insert_store_core_defines.svh"
module ordered_list_insert_store_core
  import olis_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [1:0]               mode,
  input  wire logic [POS_W-1:0]         position,
  input  wire logic signed [VAL_W-1:0]  value,
  output logic                          strobe,
  output logic signed [VAL_W-1:0]       out_value,
  output logic [OIDX_W-1:0]             out_index,
  output logic [1:0]                    status,
  output logic                          last
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SH_RD = 3'd1;
  localparam logic [2:0] S_SH_WR = 3'd2;
  localparam logic [2:0] S_INS   = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;

  logic [2:0]       state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] ptr;
  logic [CNT_W-1:0] pos;
  logic [VAL_W-1:0] val;

  logic             pend_valid;
  logic [IDX_W-1:0] pend_index;
  logic             pend_last;

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rd_data;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [VAL_W-1:0] mem_wdata;

  logic [CNT_W-1:0] ptr_dec;
  logic [CNT_W-1:0] target;
  logic             pos_bad;
  logic             accept;

  // The last read-out word is still pending after the sequencer returns
  // to idle, so a new command must wait for it.
  assign busy    = (state != S_IDLE) || pend_valid;
  assign accept  = start && !busy;
  assign ptr_dec = ptr - CNT_W'(1);

  // Insert target: the tail for append, the given position for insert.
  assign target  = (mode == MODE_APPEND) ? count : CNT_W'(position);
  assign pos_bad = (mode == MODE_INSERT) &&
                   (CMP_W'(position) > CMP_W'(count));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos[IDX_W-1:0];
    mem_wdata = val;
    rd_addr   = ptr_dec[IDX_W-1:0];
    unique case (state)
      S_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr[IDX_W-1:0];
        mem_wdata = rd_data;
      end
      S_INS: begin
        mem_we = 1'b1;
      end
      S_RD: begin
        rd_addr = ptr[IDX_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      strobe     <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      strobe     <= 1'b0;
      pend_valid <= 1'b0;

      // Read data lands in the cycle after its address; emit it then.
      if (pend_valid) begin
        strobe    <= 1'b1;
        out_value <= rd_data;
        out_index <= OIDX_W'(pend_index);
        status    <= ST_OK;
        last      <= pend_last;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            val <= value;
            if (mode == MODE_APPEND || mode == MODE_INSERT) begin
              if (pos_bad || count == CNT_W'(DEPTH)) begin
                strobe    <= 1'b1;
                out_value <= '0;
                out_index <= '0;
                status    <= pos_bad ? ST_POS : ST_FULL;
                last      <= 1'b1;
              end else begin
                pos   <= target;
                ptr   <= count;
                state <= (target == count) ? S_INS : S_SH_RD;
              end
            end else if (mode == MODE_READ) begin
              if (count == '0) begin
                strobe    <= 1'b1;
                out_value <= '0;
                out_index <= '0;
                status    <= ST_EMPTY;
                last      <= 1'b1;
              end else begin
                ptr   <= '0;
                state <= S_RD;
              end
            end
          end
        end
        S_SH_RD: begin
          state <= S_SH_WR;
        end
        S_SH_WR: begin
          ptr   <= ptr_dec;
          state <= (ptr_dec == pos) ? S_INS : S_SH_RD;
        end
        S_INS: begin
          count     <= count + CNT_W'(1);
          strobe    <= 1'b1;
          out_value <= '0;
          out_index <= '0;
          status    <= ST_OK;
          last      <= 1'b1;
          state     <= S_IDLE;
        end
        S_RD: begin
          pend_valid <= 1'b1;
          pend_index <= ptr[IDX_W-1:0];
          pend_last  <= (ptr + CNT_W'(1) == count);
          ptr        <= ptr + CNT_W'(1);
          if (ptr + CNT_W'(1) == count) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `OLIS_ASSERT(a_count_bound, count <= CNT_W'(DEPTH), "element count exceeds depth")
  `OLIS_ASSERT(a_count_step,
    !$stable(count) |-> strobe && status == ST_OK && last &&
      count == $past(count) + CNT_W'(1),
    "count changed without an ok status word")
  `OLIS_ASSERT(a_status_word,
    strobe && status != ST_OK |-> out_value == '0 && out_index == '0 && last,
    "error status word carries element data")
  `OLIS_ASSERT(a_write_state, mem_we |-> state == S_SH_WR || state == S_INS,
    "memory written outside an insert")
  `OLIS_ASSERT_ALWAYS(a_reset, rst |=> count == '0 && !strobe && !busy,
    "reset did not clear the sequencer")

endmodule
`default_nettype wire

### tb/ordered_list_insert_store_core_tb.sv
// Self-checking testbench for ordered_list_insert_store_core: a directed table, then random
// append, insert and read-out words checked against a list predictor. Depends on olis_pkg.
module ordered_list_insert_store_core_tb;
  import olis_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 80;
  localparam int MAX_GAP = 20;
  localparam int RANDOM_WORDS = 160;
  localparam int NUM_ROWS = 21;

  typedef struct packed {
    logic signed [VAL_W-1:0] val;
    logic [OIDX_W-1:0]       idx;
    logic [1:0]              st;
    logic                    lst;
  } list_word_t;

  typedef struct packed {
    logic [1:0]              mode;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] val;
    logic                    typed;
    logic [1:0]              st;
  } stim_row_t;

  // Rows marked typed carry their status word by hand; the rest go through the predictor.
  localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{MODE_READ,   6'd0,  32'sh00000000, 1'b1, ST_EMPTY},
    '{MODE_INSERT, 6'd1,  32'sh00000011, 1'b1, ST_POS},
    '{MODE_INSERT, 6'd63, 32'shFFFFFFFF, 1'b1, ST_POS},
    '{MODE_APPEND, 6'd0,  32'sh80000000, 1'b1, ST_OK},
    '{MODE_APPEND, 6'd63, 32'sh7FFFFFFF, 1'b1, ST_OK},
    '{MODE_INSERT, 6'd0,  32'shFFFFFFFF, 1'b1, ST_OK},
    '{MODE_INSERT, 6'd2,  32'sh00000000, 1'b1, ST_OK},
    '{MODE_INSERT, 6'd4,  32'sh00003039, 1'b1, ST_OK},
    '{MODE_INSERT, 6'd6,  32'sh00000007, 1'b1, ST_POS},
    '{MODE_READ,   6'd0,  32'sh00000000, 1'b0, ST_OK},
    '{MODE_UNUSED, 6'd63, 32'shFFFFFFFF, 1'b0, ST_OK},
    '{MODE_INSERT, 6'd5,  32'sh55555555, 1'b1, ST_OK},
    '{MODE_INSERT, 6'd1,  32'shAAAAAAAA, 1'b1, ST_OK},
    '{MODE_APPEND, 6'd0,  32'sh00000001, 1'b1, ST_OK},
    '{MODE_READ,   6'd63, 32'shFFFFFFFF, 1'b0, ST_OK},
    '{MODE_UNUSED, 6'd0,  32'sh00000000, 1'b0, ST_OK},
    '{MODE_INSERT, 6'd0,  32'sh0000FFFF, 1'b1, ST_OK},
    '{MODE_READ,   6'd0,  32'sh00000000, 1'b0, ST_OK},
    '{MODE_INSERT, 6'd31, 32'sh00000003, 1'b1, ST_POS},
    '{MODE_APPEND, 6'd0,  32'shFFFFFFFE, 1'b1, ST_OK},
    '{MODE_READ,   6'd0,  32'sh00000000, 1'b0, ST_OK}
  };

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic [1:0]              mode;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] value;
  logic                    strobe;
  logic signed [VAL_W-1:0] out_value;
  logic [OIDX_W-1:0]       out_index;
  logic [1:0]              status;
  logic                    last;

  logic signed [VAL_W-1:0] list_mem [DEPTH];
  int                      list_len;
  list_word_t              step_words [$];
  list_word_t              pending_words [$];
  list_word_t              head_word;
  int                      error_count = 0;
  int                      idle_cycles = 0;

  ordered_list_insert_store_core dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .mode      (mode),
    .position  (position),
    .value     (value),
    .strobe    (strobe),
    .out_value (out_value),
    .out_index (out_index),
    .status    (status),
    .last      (last)
  );

  always #5 clk = ~clk;

  function automatic logic [1:0] list_place(input int at, input logic signed [VAL_W-1:0] v);
    if (at > list_len) return ST_POS;
    if (list_len >= DEPTH) return ST_FULL;
    for (int i = list_len; i > at; i--) list_mem[i] = list_mem[i-1];
    list_mem[at] = v;
    list_len++;
    return ST_OK;
  endfunction

  // Applies one word to the list copy and leaves the words it causes in step_words.
  function automatic void list_step(input logic [1:0] m, input logic [POS_W-1:0] p,
                                    input logic signed [VAL_W-1:0] v);
    list_word_t w;
    step_words.delete();
    w = '{val: '0, idx: '0, st: ST_OK, lst: 1'b1};
    case (m)
      MODE_APPEND: begin
        w.st = list_place(list_len, v);
        step_words.push_back(w);
      end
      MODE_INSERT: begin
        w.st = list_place(int'(p), v);
        step_words.push_back(w);
      end
      MODE_READ: begin
        if (list_len == 0) begin
          w.st = ST_EMPTY;
          step_words.push_back(w);
        end else begin
          for (int i = 0; i < list_len; i++) begin
            w.val = list_mem[i];
            w.idx = i[OIDX_W-1:0];
            w.lst = (i + 1 == list_len);
            step_words.push_back(w);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return '0;
      1: return -1;
      2: return 32'sh80000000;
      3: return 32'sh7FFFFFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input logic [1:0] m, input logic [POS_W-1:0] p,
                           input logic signed [VAL_W-1:0] v, input int idle_pct,
                           input logic typed, input logic [1:0] typed_st);
    int gap;
    gap = 0;
    while (idle_pct > 0 && gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    mode     <= m;
    position <= p;
    value    <= v;
    do @(posedge clk); while (busy !== 1'b0);
    list_step(m, p, v);
    if (typed) pending_words.push_back('{val: '0, idx: '0, st: typed_st, lst: 1'b1});
    else foreach (step_words[i]) pending_words.push_back(step_words[i]);
  endtask

  task automatic check_field(input string name, input logic signed [VAL_W-1:0] want,
                             input logic signed [VAL_W-1:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (strobe) begin
        if (pending_words.size() == 0) begin
          error_count++;
          $display("%0t: unexpected word, expected none, actual %0d/%0d/%0d/%0d",
                   $time, out_value, out_index, status, last);
        end else begin
          head_word = pending_words.pop_front();
          check_field("out_value", head_word.val, out_value);
          check_field("out_index", head_word.idx, out_index);
          check_field("status", head_word.st, status);
          check_field("last", head_word.lst, last);
        end
      end
      if (strobe || (start && busy === 1'b0)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired with %0d words outstanding", $time,
                 pending_words.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int phase_idle [4];
    int sent;
    int roll;
    logic [1:0] m;
    logic [POS_W-1:0] p;
    phase_idle = '{0, 84, 17, 0};
    rst = 1'b1;
    start = 1'b0;
    mode = MODE_APPEND;
    position = '0;
    value = '0;
    list_len = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_ROWS[k])
      send_word(DIRECTED_ROWS[k].mode, DIRECTED_ROWS[k].pos, DIRECTED_ROWS[k].val, 0,
                DIRECTED_ROWS[k].typed, DIRECTED_ROWS[k].st);

    // Mostly appends and inserts at legal positions so the list fills early and the
    // full-list behavior gets a long run of reads and rejected writes.
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      if (sent == RANDOM_WORDS / 2) begin
        start <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0) @(posedge clk);
      end
      roll = $urandom_range(99);
      p = POS_W'($urandom_range(63));
      if (roll < 5) begin
        m = MODE_UNUSED;
      end else if (roll < 30) begin
        m = MODE_APPEND;
      end else if (roll < 60) begin
        m = MODE_INSERT;
        p = POS_W'($urandom_range(list_len));
      end else if (roll < 70) begin
        m = MODE_INSERT;
      end else begin
        m = MODE_READ;
      end
      send_word(m, p, pick_value(), phase_idle[(sent * 4) / RANDOM_WORDS], 1'b0, ST_OK);
      if (m != MODE_UNUSED) sent++;
    end

    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_words.size() != 0) begin
      error_count++;
      $display("%0t: %0d expected words never arrived", $time, pending_words.size());
    end
    if (error_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
